// ===== sv/trex_pkg.sv =====
// Shared constants, register codes and interface structs for the track row edge extractor.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package trex_pkg;

    localparam int WIDTH  = 64;
    localparam int HEIGHT = 64;

    localparam int ROW_W = 6;                  // row number
    localparam int COL_W = 6;                  // column number 0..WIDTH-1
    localparam int CNT_W = $clog2(WIDTH + 1);  // column count 0..WIDTH
    localparam int DRIFT_W = 7;

    localparam logic [COL_W-1:0]   CENTER_RESET = 6'd32;
    localparam logic [COL_W-1:0]   SLACK_RESET  = 6'd5;
    localparam logic [CNT_W-1:0]   WIDTH_CNT    = CNT_W'(WIDTH);
    localparam logic [COL_W-1:0]   LAST_COL     = COL_W'(WIDTH - 1);
    localparam logic [ROW_W-1:0]   LAST_ROW     = ROW_W'(HEIGHT - 1);
    localparam logic [DRIFT_W-1:0] DRIFT_MAX    = {DRIFT_W{1'b1}};

    typedef enum logic
    {
        REG_CENTER_REF = 1'b0,
        REG_FULL_SLACK = 1'b1
    } reg_sel_t;

    // Pixel statistics that do not depend on stored state.
    typedef struct packed
    {
        logic [CNT_W-1:0] white_cnt;
        logic             right_heavier;
    } row_stats_t;

    // Everything the scan stage produces for one row.
    typedef struct packed
    {
        logic [CNT_W-1:0]   left_edge;
        logic [CNT_W-1:0]   right_edge;
        logic [COL_W-1:0]   center;
        logic [CNT_W-1:0]   white_width;
        logic               all_white;
        logic               all_black;
        logic               right_heavier;
        logic [DRIFT_W-1:0] left_drift;
        logic [DRIFT_W-1:0] right_drift;
        logic               scanned;
    } scan_result_t;

endpackage

// ===== sv/track_row_edge_extractor.sv =====
// Pipeline: scan stage registers, then the result register on m_*. Throughput: one row per
// cycle while the result register is free; the center store is read at acceptance and written
// back as the row leaves the scan stage, with same-entry writes forwarded to the read register.
// Reset: rst_n clears the pipeline, drift totals and the store's valid bits at once, so every
// row center reads as 32 right away with no clearing pass; registers return to 32 and 5.
`timescale 1ns / 1ps

module track_row_edge_extractor
    import trex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input word, from bit 0 up: row_index[5:0], row_pixels[69:6], zero fill [71:70].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,
    // Result word, from bit 0 up: left_edge[6:0], right_edge[13:7], center[19:14],
    // white_width[26:20], left_drift_count[33:27], right_drift_count[40:34], zero fill.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    // Result flags, from bit 0 up: row_all_white, row_all_black, white_right_heavier.
    output logic [2:0]  m_tuser,
    // Configuration: center_reference at 0x0, full_row_slack at 0x4.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // Configuration registers; the user must write them only while the block is idle (unchecked).
    // ------------------------------------------------------------------
    logic [COL_W-1:0] center_ref_reg;
    logic [COL_W-1:0] full_slack_reg;
    reg_sel_t         reg_sel;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign reg_sel   = reg_sel_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_ref_reg <= CENTER_RESET;
            full_slack_reg <= SLACK_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_CENTER_REF: center_ref_reg <= pwdata[COL_W-1:0];
                REG_FULL_SLACK: full_slack_reg <= pwdata[COL_W-1:0];
                default:        center_ref_reg <= center_ref_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_CENTER_REF: prdata = {{(32-COL_W){1'b0}}, center_ref_reg};
            REG_FULL_SLACK: prdata = {{(32-COL_W){1'b0}}, full_slack_reg};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input decode and the acceptance stage. The row number saturates to
    // the bottom row, and the start center comes from the row below except
    // for the bottom row, which starts from its own stored center.
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] in_row;
    logic [WIDTH-1:0] in_pixels;
    logic [ROW_W-1:0] row_sat;
    logic             in_bottom;
    logic [ROW_W-1:0] start_addr;
    row_stats_t       in_stats;
    logic             in_accept;

    assign in_row    = s_tdata[ROW_W-1:0];
    assign in_pixels = s_tdata[ROW_W +: WIDTH];
    assign row_sat   = ({1'b0, in_row} >= (ROW_W + 1)'(HEIGHT)) ? LAST_ROW : in_row;
    assign in_bottom = (row_sat == LAST_ROW);
    assign start_addr = in_bottom ? row_sat : row_sat + ROW_W'(1);
    assign in_accept = s_tvalid && s_tready;

    trex_row_stats u_stats
    (
        .pixels (in_pixels),
        .stats  (in_stats)
    );

    // ------------------------------------------------------------------
    // Scan stage: the store's read data lines up with these registers.
    // ------------------------------------------------------------------
    logic             s1_valid_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_bottom_reg;
    logic [WIDTH-1:0] s1_pixels_reg;
    row_stats_t       s1_stats_reg;
    logic             s1_advance;
    logic             out_free;

    logic [DRIFT_W-1:0] left_drift_total_reg;
    logic [DRIFT_W-1:0] right_drift_total_reg;

    logic [COL_W-1:0] start_center;
    logic [COL_W-1:0] own_center;
    scan_result_t     scan;

    // The result register frees up when empty or when its word is taken.
    assign out_free   = !m_tvalid || m_tready;
    assign s1_advance = s1_valid_reg && out_free;
    assign s_tready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_row_reg    <= row_sat;
            s1_bottom_reg <= in_bottom;
            s1_pixels_reg <= in_pixels;
            s1_stats_reg  <= in_stats;
        end
    end

    // The store is read at acceptance; the row leaving the scan stage at the
    // same edge writes back and is forwarded if it hits the same entry.
    trex_center_mem u_mem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_accept),
        .rd_addr_a (start_addr),
        .rd_addr_b (row_sat),
        .wr_en     (s1_advance && scan.scanned),
        .wr_addr   (s1_row_reg),
        .wr_data   (scan.center),
        .rd_data_a (start_center),
        .rd_data_b (own_center)
    );

    trex_edge_scan u_scan
    (
        .pixels       (s1_pixels_reg),
        .stats        (s1_stats_reg),
        .start_center (start_center),
        .own_center   (own_center),
        .bottom_row   (s1_bottom_reg),
        .center_ref   (center_ref_reg),
        .full_slack   (full_slack_reg),
        .left_total   (left_drift_total_reg),
        .right_total  (right_drift_total_reg),
        .result       (scan)
    );

    // Drift totals follow the rows in order; the bottom row restarts them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_drift_total_reg  <= '0;
            right_drift_total_reg <= '0;
        end
        else if (s1_advance)
        begin
            left_drift_total_reg  <= scan.left_drift;
            right_drift_total_reg <= scan.right_drift;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic        out_valid_reg;
    logic [47:0] out_data_reg;
    logic [2:0]  out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_data_reg <= {7'b0, scan.right_drift, scan.left_drift, scan.white_width,
                             scan.center, scan.right_edge, scan.left_edge};
            out_user_reg <= {scan.right_heavier, scan.all_black, scan.all_white};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    // Input stalls only when the scan stage is full and its word cannot move on.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && m_tvalid && !m_tready))
        else $error("input stalled without a blocked scan stage");

    // After the bottom row leaves, each drift total holds at most that row's count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_bottom_reg) |=>
            (left_drift_total_reg <= DRIFT_W'(1)) && (right_drift_total_reg <= DRIFT_W'(1)))
        else $error("drift totals not restarted at the bottom row");

    // A scanned row that is not all black has its left edge left of its right edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && scan.scanned && !scan.all_black) |->
            (scan.left_edge < scan.right_edge))
        else $error("scanned edges out of order");

    // Drift totals change only when a row leaves the scan stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_advance |=> $stable(left_drift_total_reg) && $stable(right_drift_total_reg))
        else $error("drift total changed without a row");
`endif

endmodule

// ===== sv/trex_center_mem.sv =====
// Row center store: one write port, two registered read ports, forwarding of a
// same-edge write, and per-entry valid bits so unwritten rows read as the reset center.
// Depends on trex_pkg.
`timescale 1ns / 1ps

module trex_center_mem
    import trex_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [ROW_W-1:0] rd_addr_a,
    input  logic [ROW_W-1:0] rd_addr_b,
    input  logic             wr_en,
    input  logic [ROW_W-1:0] wr_addr,
    input  logic [COL_W-1:0] wr_data,
    output logic [COL_W-1:0] rd_data_a,
    output logic [COL_W-1:0] rd_data_b
);

    logic [COL_W-1:0]  center_mem_reg [HEIGHT];
    logic [HEIGHT-1:0] valid_reg;
    logic [COL_W-1:0]  q_a_reg;
    logic [COL_W-1:0]  q_b_reg;
    logic              qv_a_reg;
    logic              qv_b_reg;
    logic              fwd_a;
    logic              fwd_b;

    assign fwd_a = wr_en && (wr_addr == rd_addr_a);
    assign fwd_b = wr_en && (wr_addr == rd_addr_b);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            center_mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            q_a_reg <= fwd_a ? wr_data : center_mem_reg[rd_addr_a];
            q_b_reg <= fwd_b ? wr_data : center_mem_reg[rd_addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            qv_a_reg  <= 1'b0;
            qv_b_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                qv_a_reg <= fwd_a || valid_reg[rd_addr_a];
                qv_b_reg <= fwd_b || valid_reg[rd_addr_b];
            end
        end
    end

    assign rd_data_a = qv_a_reg ? q_a_reg : CENTER_RESET;
    assign rd_data_b = qv_b_reg ? q_b_reg : CENTER_RESET;

endmodule

// ===== sv/trex_row_stats.sv =====
// White pixel counts of an incoming row: total count and which half holds more white.
// Depends on trex_pkg.
`timescale 1ns / 1ps

module trex_row_stats
    import trex_pkg::*;
(
    input  logic [WIDTH-1:0] pixels,
    output row_stats_t       stats
);

    logic [CNT_W-1:0] left_white;
    logic [CNT_W-1:0] right_white;

    always_comb
    begin
        left_white  = '0;
        right_white = '0;
        for (int c = 0; c < WIDTH / 2; c++)
        begin
            left_white = left_white + {{(CNT_W-1){1'b0}}, ~pixels[c]};
        end
        for (int c = WIDTH / 2; c < WIDTH; c++)
        begin
            right_white = right_white + {{(CNT_W-1){1'b0}}, ~pixels[c]};
        end
        stats.white_cnt     = left_white + right_white;
        stats.right_heavier = right_white > left_white;
    end

endmodule

// ===== sv/trex_edge_scan.sv =====
// Edge scan from the start column, new center, row flags and drift counting.
// Purely combinational; depends on trex_pkg.
`timescale 1ns / 1ps

module trex_edge_scan
    import trex_pkg::*;
(
    input  logic [WIDTH-1:0]   pixels,
    input  row_stats_t         stats,
    input  logic [COL_W-1:0]   start_center,
    input  logic [COL_W-1:0]   own_center,
    input  logic               bottom_row,
    input  logic [COL_W-1:0]   center_ref,
    input  logic [COL_W-1:0]   full_slack,
    input  logic [DRIFT_W-1:0] left_total,
    input  logic [DRIFT_W-1:0] right_total,
    output scan_result_t       result
);

    logic [COL_W-1:0]   mid;
    logic [CNT_W-1:0]   left;
    logic [CNT_W-1:0]   right;
    logic [CNT_W:0]     edge_sum;
    logic [CNT_W:0]     white_plus_slack;
    logic [DRIFT_W-1:0] base_l;
    logic [DRIFT_W-1:0] base_r;
    logic               start_white;
    logic               all_white;
    logic               all_black;

    always_comb
    begin
        // A start column outside the row is pinned to the last column.
        if ({1'b0, start_center} >= WIDTH_CNT)
        begin
            mid = LAST_COL;
        end
        else
        begin
            mid = start_center;
        end
        start_white = ~pixels[mid];

        // Nearest black column on each side of the start column.
        left  = '0;
        right = WIDTH_CNT;
        for (int c = 0; c < WIDTH; c++)
        begin
            if (pixels[c] && (COL_W'(c) < mid))
            begin
                left = CNT_W'(c);
            end
        end
        for (int c = WIDTH - 1; c >= 0; c--)
        begin
            if (pixels[c] && (COL_W'(c) > mid))
            begin
                right = CNT_W'(c);
            end
        end

        white_plus_slack = {1'b0, stats.white_cnt} + (CNT_W + 1)'(full_slack);
        all_white = white_plus_slack > {1'b0, WIDTH_CNT};
        all_black = !all_white && ({1'b0, full_slack} > stats.white_cnt);

        base_l = bottom_row ? '0 : left_total;
        base_r = bottom_row ? '0 : right_total;

        edge_sum = {1'b0, left} + {1'b0, right};

        result.left_edge     = '0;
        result.right_edge    = WIDTH_CNT;
        result.center        = own_center;
        result.white_width   = stats.white_cnt;
        result.all_white     = all_white;
        result.all_black     = all_black;
        result.right_heavier = stats.right_heavier;
        result.left_drift    = base_l;
        result.right_drift   = base_r;
        result.scanned       = start_white;

        if (start_white)
        begin
            result.left_edge  = left;
            result.right_edge = right;
            if ((left > {1'b0, center_ref}) && (base_l != DRIFT_MAX))
            begin
                result.left_drift = base_l + DRIFT_W'(1);
            end
            if ((right < {1'b0, center_ref}) && (base_r != DRIFT_MAX))
            begin
                result.right_drift = base_r + DRIFT_W'(1);
            end
            if (all_black)
            begin
                result.center      = center_ref;
                result.white_width = '0;
            end
            else
            begin
                result.center      = edge_sum[COL_W:1];
                result.white_width = right - left;
            end
        end
    end

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the track row edge extractor: drives row words and APB
// register writes, predicts every result word and compares it field by field.
// Depends on trex_pkg and the track_row_edge_extractor module only.
`timescale 1ns / 1ps

module tb;
    import trex_pkg::*;

    localparam int CYCLE_LIMIT = 400000;   // far above the slowest correct run
    localparam int HOLD_CYCLES = 300;      // long receiver hold-off, fills the pipeline

    // One expected result word with its flags.
    typedef struct
    {
        logic [CNT_W-1:0]   left_edge;
        logic [CNT_W-1:0]   right_edge;
        logic [COL_W-1:0]   center;
        logic [CNT_W-1:0]   white_width;
        logic               all_white;
        logic               all_black;
        logic               right_heavier;
        logic [DRIFT_W-1:0] left_drift;
        logic [DRIFT_W-1:0] right_drift;
    } row_result_t;

    // Keeps its own copy of the center store, the drift totals and both registers,
    // works out the result of every accepted row word and checks the words that leave.
    class edge_scoreboard;
        logic [COL_W-1:0] row_center [HEIGHT];
        int unsigned      left_drift;
        int unsigned      right_drift;
        logic [COL_W-1:0] center_ref;
        logic [COL_W-1:0] row_slack;
        row_result_t      pending_rows[$];
        int unsigned      mismatches;

        function new();
            foreach (row_center[i])
                row_center[i] = CENTER_RESET;
            left_drift  = 0;
            right_drift = 0;
            center_ref  = CENTER_RESET;
            row_slack   = SLACK_RESET;
            mismatches  = 0;
        endfunction

        function void write_reg(reg_sel_t sel, logic [COL_W-1:0] value);
            if (sel == REG_CENTER_REF)
                center_ref = value;
            else
                row_slack = value;
        endfunction

        function int pending();
            return pending_rows.size();
        endfunction

        function void note_row(logic [ROW_W-1:0] row, logic [WIDTH-1:0] pixels);
            int          white_lo;
            int          white_hi;
            int          white_all;
            int          limit;
            int          start;
            int          left;
            int          right;
            int          c;
            row_result_t res;

            // The bottom row opens a new frame, so the drift totals start over.
            if (row == LAST_ROW)
            begin
                left_drift  = 0;
                right_drift = 0;
            end

            white_lo  = $countones(~pixels[WIDTH/2-1:0]);
            white_hi  = $countones(~pixels[WIDTH-1:WIDTH/2]);
            white_all = white_lo + white_hi;
            // The threshold is signed: a slack beyond the width makes it negative.
            limit     = WIDTH - int'(row_slack);

            res.all_white     = white_all > limit;
            res.all_black     = !res.all_white && (WIDTH - white_all) > limit;
            res.right_heavier = white_hi > white_lo;

            // Scan starts at the center of the row below, or at its own for the bottom row.
            start = (row == LAST_ROW) ? int'(row_center[row]) : int'(row_center[int'(row) + 1]);

            res.left_edge   = '0;
            res.right_edge  = WIDTH_CNT;
            res.white_width = CNT_W'(white_all);
            res.center      = row_center[row];

            if (!pixels[start])
            begin
                left  = 0;
                right = WIDTH;
                for (c = start - 1; c >= 0; c--)
                    if (pixels[c])
                    begin
                        left = c;
                        break;
                    end
                for (c = start + 1; c < WIDTH; c++)
                    if (pixels[c])
                    begin
                        right = c;
                        break;
                    end
                if (left > int'(center_ref) && left_drift < DRIFT_MAX)
                    left_drift++;
                if (right < int'(center_ref) && right_drift < DRIFT_MAX)
                    right_drift++;
                if (!res.all_black)
                begin
                    res.center      = COL_W'((left + right) / 2);
                    res.white_width = CNT_W'(right - left);
                end
                else
                begin
                    // A black row falls back to the reference center.
                    res.center      = center_ref;
                    res.white_width = '0;
                end
                row_center[row] = res.center;
                res.left_edge   = CNT_W'(left);
                res.right_edge  = CNT_W'(right);
            end

            res.left_drift  = DRIFT_W'(left_drift);
            res.right_drift = DRIFT_W'(right_drift);
            pending_rows.push_back(res);
        endfunction

        function void compare_field(string name, int unsigned expected_val,
                                    int unsigned actual_val);
            if (expected_val != actual_val)
            begin
                $error("%s: expected %0d, got %0d", name, expected_val, actual_val);
                mismatches++;
            end
        endfunction

        function void check_result(logic [47:0] data, logic [2:0] flags);
            row_result_t res;
            if (pending_rows.size() == 0)
            begin
                $error("result word arrived with no row pending");
                mismatches++;
                return;
            end
            res = pending_rows.pop_front();
            compare_field("left_edge",           res.left_edge,     data[6:0]);
            compare_field("right_edge",          res.right_edge,    data[13:7]);
            compare_field("center",              res.center,        data[19:14]);
            compare_field("white_width",         res.white_width,   data[26:20]);
            compare_field("left_drift_count",    res.left_drift,    data[33:27]);
            compare_field("right_drift_count",   res.right_drift,   data[40:34]);
            compare_field("row_all_white",       res.all_white,     flags[0]);
            compare_field("row_all_black",       res.all_black,     flags[1]);
            compare_field("white_right_heavier", res.right_heavier, flags[2]);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // Input word, from bit 0 up: row_index[5:0], row_pixels[69:6], zero fill [71:70].
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // Result word, from bit 0 up: left_edge, right_edge, center, white_width,
    // left_drift_count, right_drift_count, zero fill.
    logic [47:0] m_tdata;
    // Result flags, from bit 0 up: row_all_white, row_all_black, white_right_heavier.
    logic [2:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    edge_scoreboard edges;
    bit             src_gaps = 1'b1;    // sender idles at random when set
    bit             sink_gaps = 1'b1;   // receiver stalls at random when set
    bit             hold_ready = 1'b0;  // asks the receiver for one long hold-off
    int unsigned    cycle_count = 0;

    track_row_edge_extractor DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // All inputs change just after a rising edge, so at the falling edge every handshake
    // signal already shows what the next rising edge will see. Both sides are sampled
    // there: a row word is noted before the edge that accepts it, a result word is
    // checked before the edge that takes it.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                edges.note_row(s_tdata[5:0], s_tdata[69:6]);
            if (m_tvalid && m_tready)
                edges.check_result(m_tdata, m_tuser);
        end
    end

    // Receiver: random stalls, no stalls at all, or one long hold-off counted here.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_ready)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_ready = 1'b0;
            end
            else
                m_tready <= !(sink_gaps && $urandom_range(99) < 35);
        end
    end

    // A run that hangs ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offers one row word and returns at the rising edge that accepts it. It is always
    // entered at a rising edge, so s_tvalid gets one assignment per time step.
    task automatic send_row(input logic [ROW_W-1:0] row, input logic [WIDTH-1:0] pixels);
        while (src_gaps && $urandom_range(99) < 35)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, pixels, row};
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
    endtask

    // Stops offering and waits until every expected result word has come out of the two-stage
    // pipeline, then lets the clock run on before it returns.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (edges.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes the value at the
    // edge that ends the access cycle. Upper data bits carry junk the block must drop.
    task automatic write_reg(input reg_sel_t sel, input logic [COL_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {26'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        edges.write_reg(sel, value);
    endtask

    // A track seen from above: white between lo and hi, black outside, plus a few
    // flipped pixels of noise.
    function automatic logic [WIDTH-1:0] band_row(input int lo, input int hi);
        logic [WIDTH-1:0] pixels;
        int               flips;
        int               col;
        for (int c = 0; c < WIDTH; c++)
            pixels[c] = (c < lo) || (c > hi);
        flips = $urandom_range(0, 3);
        repeat (flips)
        begin
            col = $urandom_range(0, WIDTH - 1);
            pixels[col] = ~pixels[col];
        end
        return pixels;
    endfunction

    // Rows from top down to 0. A step of 1 from the bottom row gives a well-formed frame;
    // a larger step from a random row gives a broken one. Most rows follow a wandering
    // track that narrows toward the horizon; the rest are solid or random.
    task automatic send_frame(input int top, input int max_step);
        int               row;
        int               mid;
        int               half;
        int               kind;
        logic [WIDTH-1:0] pixels;
        row  = top;
        mid  = $urandom_range(4, WIDTH - 5);
        half = $urandom_range(10, 34);
        while (row >= 0)
        begin
            kind = $urandom_range(99);
            if (kind < 80)
            begin
                mid = mid + $urandom_range(0, 4) - 2;
                if (mid < 0)
                    mid = 0;
                if (mid > WIDTH - 1)
                    mid = WIDTH - 1;
                if (half > 2 && $urandom_range(1) == 1)
                    half--;
                pixels = band_row(mid - half, mid + half);
            end
            else if (kind < 85)
                pixels = '1;
            else if (kind < 90)
                pixels = '0;
            else
                pixels = {$urandom, $urandom};
            send_row(ROW_W'(row), pixels);
            // Now and then the sender waits for the pipeline to empty mid-frame.
            if ($urandom_range(199) == 0)
                drain();
            row = row - $urandom_range(1, max_step);
        end
    endtask

    // Rows without the bottom row keep the drift totals counting, up to saturation.
    task automatic send_drift_run(input logic [WIDTH-1:0] pixels, input int count);
        repeat (count)
            send_row(ROW_W'($urandom_range(0, HEIGHT - 2)), pixels);
    endtask

    task automatic send_noise(input int count);
        repeat (count)
            send_row(ROW_W'($urandom), {$urandom, $urandom});
    endtask

    initial
    begin
        edges = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows at the reset settings (reference 32, slack 5).
        send_row(LAST_ROW, '0);                          // all white, no edge either side
        send_row(6'd62, '1);                             // all black, start pixel black
        send_row(6'd61, ~(64'd1 << 32));                 // one white pixel at the start
        send_row(6'd60, 64'h0000_0000_FFFF_FFFF);        // white right half only
        send_row(6'd59, 64'hFFFF_FFFF_0000_0000);        // white left half, start black
        send_row(6'd58, band_row(10, 50));
        send_row(6'd57, 64'h8000_0000_0000_0001);        // black only at both borders
        send_row(6'd56, 64'h5555_5555_5555_5555);
        send_row(6'd55, 64'hAAAA_AAAA_AAAA_AAAA);
        send_row(6'd54, 64'h0000_0000_0000_001F);        // just outside all-white slack
        send_row(6'd53, 64'hFFFF_FFFF_FFFF_FFE0);        // just outside all-black slack
        send_row(6'd52, ~(64'h3F << 29));                // narrow white gap, nearly black
        send_row(6'd1,  band_row(40, 62));               // edges right of the reference
        send_row(6'd0,  band_row(2, 20));                // row 0 starts from row 1's center
        send_row(6'd20, band_row(0, 63));
        send_row(LAST_ROW, '1);                          // bottom row, start pixel black
        send_row(LAST_ROW, band_row(36, 60));            // bottom row scans from itself
        send_row(6'd62, band_row(0, 27));                // start pixel black, so no drift counted
        send_row(6'd61, 64'h8000_0000_0000_0000);        // black only in the last column

        // Reference at column 0 and zero slack: all-white can never be reached.
        drain();
        write_reg(REG_CENTER_REF, 6'd0);
        write_reg(REG_FULL_SLACK, 6'd0);
        repeat (5) send_frame(HEIGHT - 1, 1);
        send_drift_run(64'h0000_0000_0000_0002, 160);   // left edge at column 1 every row
        send_noise(40);

        // Reference at the last column, slack at its top: thresholds near zero.
        drain();
        write_reg(REG_CENTER_REF, 6'd63);
        write_reg(REG_FULL_SLACK, 6'd63);
        repeat (5) send_frame(HEIGHT - 1, 1);
        send_drift_run(64'h4000_0000_0000_0000, 160);   // right edge at column 62 every row
        send_noise(40);

        // Random settings, with well-formed frames, broken frames and noise.
        for (int phase = 0; phase < 3; phase++)
        begin
            drain();
            write_reg(REG_CENTER_REF, COL_W'($urandom_range(0, WIDTH - 1)));
            write_reg(REG_FULL_SLACK, COL_W'($urandom_range(0, 63)));
            repeat (3) send_frame(HEIGHT - 1, 1);
            repeat (4) send_frame($urandom_range(0, HEIGHT - 1), 3);
            send_noise(30);
        end

        // Back to the reset values; first a stretch with no idling on either side.
        drain();
        write_reg(REG_CENTER_REF, CENTER_RESET);
        write_reg(REG_FULL_SLACK, SLACK_RESET);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        repeat (2) send_frame(HEIGHT - 1, 1);
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;

        // The receiver holds off for a long time while rows keep being offered, so the
        // block fills up and has to stall its input.
        hold_ready = 1'b1;
        send_frame(HEIGHT - 1, 1);

        drain();
        repeat (10) @(posedge clk);
        if (edges.mismatches == 0 && edges.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
